// ===== hdl/grdda_pkg.sv =====
// Shared types and constants for the grid ray caster.
package grdda_pkg;

  // Input item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_PLAYER_X     = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y     = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_CAM_PLANE_X  = 3'd4;
  localparam logic [2:0] REG_CAM_PLANE_Y  = 3'd5;
  localparam logic [2:0] REG_SCREEN_WIDTH = 3'd6;

  // Wall map size in cells; the cell ports and the Q6.10 position fix it at 64.
  localparam int unsigned MAP_WIDTH  = 64;
  localparam int unsigned MAP_HEIGHT = 64;

  // Largest distance in Q10.14.
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  // Divider command and response between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [28:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [28:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/grdda_div.sv =====
// Restoring divider, one quotient bit per cycle.
module grdda_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grdda_pkg::div_req_t req_i,
  output grdda_pkg::div_rsp_t rsp_o
);

  logic [28:0] quo_q, quo_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  // One shift and subtract step.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[16:0], quo_q[28]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[27:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[27:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd28) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/grdda_map.sv =====
// Wall map memory with a clearing pass after reset.
module grdda_map #(
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o,
  output logic          clearing_o
);

  logic          mem [2**AW];
  logic [AW-1:0] clr_q;
  logic          clearing_q;

  // Clear sweep, one entry a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == {AW{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= 1'b0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

  assign clearing_o = clearing_q;

endmodule

// ===== hdl/grid_ray_dda_caster_core.sv =====
// Top level of the grid ray caster: configuration, sequencer and DDA walk.
//
// Usage: an input transfer with kind 0 writes one wall map cell and gives no
// result. kind 1 casts the ray of one screen column and gives one result
// transfer. Items are taken one at a time; in_valid_i/in_stall_o and
// out_valid_o/out_stall_i follow a valid and stall handshake.
// A write leaves the sequencer idle, and write items can follow back to back.
// A cast first runs its setup up to the first DDA step: a camera division and
// two reciprocal divisions on the shared 29-step bit-serial divider, plus the
// multiplies (a division is skipped when its ray component is zero). Each DDA
// step then addresses the map in S_STEP and tests the read bit in S_CHECK,
// for up to MAP_WIDTH+MAP_HEIGHT steps, and the result is registered in S_DONE
// once the output register is free.
// After reset the wall map is cleared one cell a cycle, during which no input
// is taken; configuration writes are taken at any time.
// The result sits in an output register; the next item is accepted while it
// waits, and a finished cast holds at the end of its walk until the receiver
// takes the waiting result. Configuration must only be written while idle.
module grid_ray_dda_caster_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [10:0] column_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        wall_bit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] column_out_o,
  output logic [5:0]  hit_x_o,
  output logic [5:0]  hit_y_o,
  output logic        hit_side_o,
  output logic [23:0] wall_distance_o,
  output logic        escaped_o
);

  localparam int unsigned MAP_WIDTH  = grdda_pkg::MAP_WIDTH;
  localparam int unsigned MAP_HEIGHT = grdda_pkg::MAP_HEIGHT;
  localparam int unsigned XW = $clog2(MAP_WIDTH);
  localparam int unsigned YW = $clog2(MAP_HEIGHT);
  localparam int unsigned AW = XW + YW;

  // Configuration registers.
  logic [15:0] px_q, py_q, dirx_q, diry_q, plx_q, ply_q;
  logic [11:0] sw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= 16'd1536;
      py_q   <= 16'd1536;
      dirx_q <= 16'd16384;
      diry_q <= 16'd0;
      plx_q  <= 16'd0;
      ply_q  <= 16'd10813;
      sw_q   <= 12'd640;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        grdda_pkg::REG_PLAYER_X:     px_q   <= cfg_data_i;
        grdda_pkg::REG_PLAYER_Y:     py_q   <= cfg_data_i;
        grdda_pkg::REG_VIEW_DIR_X:   dirx_q <= cfg_data_i;
        grdda_pkg::REG_VIEW_DIR_Y:   diry_q <= cfg_data_i;
        grdda_pkg::REG_CAM_PLANE_X:  plx_q  <= cfg_data_i;
        grdda_pkg::REG_CAM_PLANE_Y:  ply_q  <= cfg_data_i;
        grdda_pkg::REG_SCREEN_WIDTH: sw_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  typedef enum logic [3:0] {
    S_IDLE, S_CAM, S_RAY, S_RAY2, S_DX, S_DY, S_FRAC, S_SIDE, S_STEP, S_CHECK, S_DONE
  } state_e;

  state_e      state_q;
  logic [10:0] col_q;
  logic signed [31:0] prodx_q, prody_q;
  logic signed [17:0] rdx_q, rdy_q;
  logic [23:0] dx_q, dy_q, sx_q, sy_q;
  logic [33:0] fpx_q, fpy_q;
  logic signed [XW+1:0] mx_q;
  logic signed [YW+1:0] my_q;
  logic        side_q;
  logic        pend_q, pend_d;
  logic [10:0] rcol_q;
  logic [5:0]  rhx_q, rhy_q;
  logic        rside_q, resc_q;
  logic [23:0] rdist_q;

  grdda_pkg::div_req_t div_req;
  grdda_pkg::div_rsp_t div_rsp;

  grdda_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic          map_we, map_rd, clearing;
  logic [AW-1:0] map_waddr, map_raddr;

  grdda_map #(.AW(AW)) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (map_we),
    .waddr_i    (map_waddr),
    .wdata_i    (wall_bit_i),
    .raddr_i    (map_raddr),
    .rdata_o    (map_rd),
    .clearing_o (clearing)
  );

  logic in_xfer, out_xfer;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign in_stall_o = clearing || (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Map writes from write items inside the grid.
  assign map_we = in_xfer && (kind_i == grdda_pkg::KIND_WRITE)
                  && ({2'b0, cell_x_i} < 8'(MAP_WIDTH)) && ({2'b0, cell_y_i} < 8'(MAP_HEIGHT));
  assign map_waddr = {cell_y_i[YW-1:0], cell_x_i[XW-1:0]};

  // Helpers for the divider operands and camera value.
  logic [11:0] sw_eff;
  assign sw_eff = (sw_q == 12'd0) ? 12'd1 : sw_q;
  logic [17:0] cam_raw;
  logic [15:0] cam_sat;
  assign cam_raw = {1'b0, div_rsp.quotient[16:0]} - 18'd16384;
  always_comb begin
    if (div_rsp.quotient[28:17] != '0) begin
      cam_sat = 16'h7FFF;
    end else if (!cam_raw[17] && cam_raw[16:15] != 2'b00) begin
      cam_sat = 16'h7FFF;
    end else begin
      cam_sat = cam_raw[15:0];
    end
  end

  // Truncating divide by 2^14 of a signed product.
  function automatic logic signed [17:0] tdiv14(input logic signed [31:0] p);
    logic signed [31:0] adj;
    adj = p[31] ? (p + 32'sd16383) : p;
    return 18'(adj >>> 14);
  endfunction

  logic [16:0] absx, absy;
  assign absx = rdx_q[17] ? 17'(-rdx_q) : 17'(rdx_q);
  assign absy = rdy_q[17] ? 17'(-rdy_q) : 17'(rdy_q);

  function automatic logic [23:0] sat24(input logic [28:0] q);
    return (q[28:24] != '0) ? grdda_pkg::DIST_MAX : q[23:0];
  endfunction

  logic [10:0] fx, fy;
  assign fx = rdx_q[17] ? {1'b0, px_q[9:0]} : (11'd1024 - {1'b0, px_q[9:0]});
  assign fy = rdy_q[17] ? {1'b0, py_q[9:0]} : (11'd1024 - {1'b0, py_q[9:0]});

  logic [24:0] sumx, sumy;
  assign sumx = {1'b0, sx_q} + {1'b0, dx_q};
  assign sumy = {1'b0, sy_q} + {1'b0, dy_q};

  logic step_x;
  assign step_x = sx_q < sy_q;

  logic [XW+1:0] nmx;
  logic [YW+1:0] nmy;
  assign nmx = step_x ? (rdx_q[17] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
  assign nmy = step_x ? my_q : (rdy_q[17] ? my_q - 1'b1 : my_q + 1'b1);
  logic nout;
  assign nout = nmx[XW+1] || nmy[YW+1] || (nmx >= (XW+2)'(MAP_WIDTH))
                || (nmy >= (YW+2)'(MAP_HEIGHT));
  assign map_raddr = {nmy[YW-1:0], nmx[XW-1:0]};

  logic [23:0] dist_w;
  assign dist_w = side_q ? (sy_q - dy_q) : (sx_q - dx_q);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (in_xfer && kind_i == grdda_pkg::KIND_CAST) begin
      div_req.start    = 1'b1;
      div_req.dividend = {3'b0, column_i, 15'b0};
      div_req.divisor  = {5'b0, sw_eff};
    end else if (state_q == S_RAY2 && absx != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = 29'h1000_0000;
      div_req.divisor  = absx;
    end else if (state_q == S_RAY2 && absy != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = 29'h1000_0000;
      div_req.divisor  = absy;
    end else if (state_q == S_DX && div_rsp.done && absy != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = 29'h1000_0000;
      div_req.divisor  = absy;
    end
  end

  // The output register is freed by a result transfer and filled when a cast ends.
  always_comb begin
    pend_d = pend_q;
    if (out_xfer) begin
      pend_d = 1'b0;
    end
    if (state_q == S_DONE && (!pend_q || out_xfer)) begin
      pend_d = 1'b1;
    end
  end

  // Sequencer: setup, DDA walk and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      case (state_q)
        S_IDLE: begin
          if (in_xfer && kind_i == grdda_pkg::KIND_CAST) begin
            state_q <= S_CAM;
          end
        end
        S_CAM: begin
          if (div_rsp.done) begin
            state_q <= S_RAY;
          end
        end
        S_RAY:  state_q <= S_RAY2;
        S_RAY2: state_q <= (absx == '0) ? ((absy == '0) ? S_FRAC : S_DY) : S_DX;
        S_DX: begin
          if (div_rsp.done) begin
            state_q <= (absy == '0) ? S_FRAC : S_DY;
          end
        end
        S_DY: begin
          if (div_rsp.done) begin
            state_q <= S_FRAC;
          end
        end
        S_FRAC: state_q <= S_SIDE;
        S_SIDE: begin
          state_q <= ((mx_q >= (XW+2)'(MAP_WIDTH)) || (my_q >= (YW+2)'(MAP_HEIGHT)))
                     ? S_DONE : S_STEP;
        end
        S_STEP: state_q <= nout ? S_DONE : S_CHECK;
        S_CHECK: state_q <= map_rd ? S_DONE : S_STEP;
        S_DONE: begin
          if (!pend_q || out_xfer) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        col_q   <= column_i;
        side_q  <= 1'b0;
        resc_q  <= 1'b0;
        rhx_q   <= '0;
        rhy_q   <= '0;
        dx_q    <= grdda_pkg::DIST_MAX;
        dy_q    <= grdda_pkg::DIST_MAX;
      end
      S_CAM: begin
        prodx_q <= 32'($signed(plx_q) * $signed(cam_sat));
        prody_q <= 32'($signed(ply_q) * $signed(cam_sat));
      end
      S_RAY: begin
        rdx_q <= 18'($signed(dirx_q)) + tdiv14(prodx_q);
        rdy_q <= 18'($signed(diry_q)) + tdiv14(prody_q);
      end
      S_DX: if (div_rsp.done) dx_q <= sat24(div_rsp.quotient);
      S_DY: if (div_rsp.done) dy_q <= sat24(div_rsp.quotient);
      S_FRAC: begin
        fpx_q <= 34'(fx * dx_q);
        fpy_q <= 34'(fy * dy_q);
        mx_q  <= (XW+2)'(px_q[15:10]);
        my_q  <= (YW+2)'(py_q[15:10]);
      end
      S_SIDE: begin
        // A 34-bit product shifted by 10 always fits the 24-bit distance.
        sx_q <= fpx_q[33:10];
        sy_q <= fpy_q[33:10];
        if ((mx_q >= (XW+2)'(MAP_WIDTH)) || (my_q >= (YW+2)'(MAP_HEIGHT))) begin
          resc_q <= 1'b1;
        end
      end
      S_STEP: begin
        if (step_x) begin
          sx_q   <= sumx[24] ? grdda_pkg::DIST_MAX : sumx[23:0];
          side_q <= 1'b0;
        end else begin
          sy_q   <= sumy[24] ? grdda_pkg::DIST_MAX : sumy[23:0];
          side_q <= 1'b1;
        end
        mx_q <= nmx;
        my_q <= nmy;
        if (nout) resc_q <= 1'b1;
      end
      S_CHECK: begin
        if (map_rd) begin
          rhx_q <= 6'(mx_q[XW-1:0]);
          rhy_q <= 6'(my_q[YW-1:0]);
        end
      end
      S_DONE: begin
        if (!pend_q || out_xfer) begin
          rcol_q  <= col_q;
          rside_q <= side_q;
          rdist_q <= dist_w;
        end
      end
      default: ;
    endcase
  end

  // A start cell outside the grid reports zero side and distance.
  logic start_out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_SIDE) begin
      start_out_q <= (mx_q >= (XW+2)'(MAP_WIDTH)) || (my_q >= (YW+2)'(MAP_HEIGHT));
    end
  end
  logic rzero_q, rescf_q;
  logic [5:0] rhxf_q, rhyf_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!pend_q || out_xfer)) begin
      rzero_q <= start_out_q;
      rescf_q <= resc_q;
      rhxf_q  <= resc_q ? 6'd0 : rhx_q;
      rhyf_q  <= resc_q ? 6'd0 : rhy_q;
    end
  end

  assign out_valid_o     = pend_q;
  assign column_out_o    = rcol_q;
  assign hit_x_o         = rhxf_q;
  assign hit_y_o         = rhyf_q;
  assign hit_side_o      = rzero_q ? 1'b0 : rside_q;
  assign wall_distance_o = rzero_q ? '0 : rdist_q;
  assign escaped_o       = rescf_q;

endmodule

// ===== tb/grid_ray_dda_caster_core_checker.sv =====
// Checker for the grid ray caster: mirrors configuration and wall map, predicts casts, compares.
`timescale 1ns / 1ps
module grid_ray_dda_caster_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [10:0] column_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        wall_bit_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [10:0] column_out_i,
  input  logic [5:0]  hit_x_i,
  input  logic [5:0]  hit_y_i,
  input  logic        hit_side_i,
  input  logic [23:0] wall_distance_i,
  input  logic        escaped_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          hits_seen_o,
  output int          escapes_seen_o
);

  localparam int GRID = 64;

  typedef struct packed {
    logic [10:0] column;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        hit_side;
    logic [23:0] distance;
    logic        escaped;
  } ray_hit_t;

  // Mirrored configuration and wall map.
  logic [15:0] pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
  logic [11:0] scr_w;
  logic        walls [GRID*GRID];
  ray_hit_t    hit_queue [$];

  // Reciprocal step length of one ray component, Q10.14.
  function automatic longint step_len(input longint comp);
    longint q;
    if (comp == 0) return longint'(grdda_pkg::DIST_MAX);
    q = (longint'(1) <<< 28) / (comp < 0 ? -comp : comp);
    return q > longint'(grdda_pkg::DIST_MAX) ? longint'(grdda_pkg::DIST_MAX) : q;
  endfunction

  function automatic longint clip_dist(input longint v);
    return v > longint'(grdda_pkg::DIST_MAX) ? longint'(grdda_pkg::DIST_MAX) : v;
  endfunction

  // Walk the grid for one screen column under the current configuration.
  function automatic ray_hit_t trace_column(input logic [10:0] col);
    ray_hit_t r;
    longint w, cam, rdx, rdy, dx, dy, sx, sy, mx, my, stx, sty, fx, fy;
    logic side;
    r = '0;
    r.column = col;
    side = 1'b0;
    w = (scr_w == 0) ? 1 : longint'(scr_w);
    cam = (longint'(col) <<< 15) / w - 16384;
    if (cam > 32767) cam = 32767;
    if (cam < -32768) cam = -32768;
    rdx = longint'($signed(dir_x)) + (longint'($signed(plane_x)) * cam) / 16384;
    rdy = longint'($signed(dir_y)) + (longint'($signed(plane_y)) * cam) / 16384;
    dx = step_len(rdx);
    dy = step_len(rdy);
    mx = longint'(pos_x[15:10]);
    my = longint'(pos_y[15:10]);
    fx = longint'(pos_x[9:0]);
    fy = longint'(pos_y[9:0]);
    stx = rdx < 0 ? -1 : 1;
    sty = rdy < 0 ? -1 : 1;
    sx = clip_dist(((rdx < 0 ? fx : 1024 - fx) * dx) >>> 10);
    sy = clip_dist(((rdy < 0 ? fy : 1024 - fy) * dy) >>> 10);
    if (mx >= GRID || my >= GRID) begin
      r.escaped = 1'b1;
      return r;
    end
    forever begin
      if (sx < sy) begin
        sx = clip_dist(sx + dx);
        mx += stx;
        side = 1'b0;
      end else begin
        sy = clip_dist(sy + dy);
        my += sty;
        side = 1'b1;
      end
      if (mx < 0 || my < 0 || mx >= GRID || my >= GRID) begin
        r.escaped = 1'b1;
        break;
      end
      if (walls[my*GRID + mx]) begin
        r.hit_x = mx[5:0];
        r.hit_y = my[5:0];
        break;
      end
    end
    r.hit_side = side;
    r.distance = 24'(side ? sy - dy : sx - dx);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  assign pending_o = hit_queue.size();

  // Track configuration, map writes and cast transfers; check result transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    ray_hit_t want;
    if (!rst_ni) begin
      pos_x   <= 16'd1536;
      pos_y   <= 16'd1536;
      dir_x   <= 16'd16384;
      dir_y   <= 16'd0;
      plane_x <= 16'd0;
      plane_y <= 16'd10813;
      scr_w   <= 12'd640;
      foreach (walls[i]) walls[i] = 1'b0;
      hit_queue.delete();
      fail_count_o   = 0;
      hits_seen_o    = 0;
      escapes_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          grdda_pkg::REG_PLAYER_X:     pos_x   <= cfg_data_i;
          grdda_pkg::REG_PLAYER_Y:     pos_y   <= cfg_data_i;
          grdda_pkg::REG_VIEW_DIR_X:   dir_x   <= cfg_data_i;
          grdda_pkg::REG_VIEW_DIR_Y:   dir_y   <= cfg_data_i;
          grdda_pkg::REG_CAM_PLANE_X:  plane_x <= cfg_data_i;
          grdda_pkg::REG_CAM_PLANE_Y:  plane_y <= cfg_data_i;
          grdda_pkg::REG_SCREEN_WIDTH: scr_w   <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == grdda_pkg::KIND_WRITE) walls[cell_y_i*GRID + cell_x_i] = wall_bit_i;
        else hit_queue.push_back(trace_column(column_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: result transfer with nothing expected, column %0d",
                   $time, column_out_i);
          fail_count_o++;
        end else begin
          want = hit_queue.pop_front();
          check_field("column_out", 24'(want.column), 24'(column_out_i));
          check_field("hit_x", 24'(want.hit_x), 24'(hit_x_i));
          check_field("hit_y", 24'(want.hit_y), 24'(hit_y_i));
          check_field("hit_side", 24'(want.hit_side), 24'(hit_side_i));
          check_field("wall_distance", want.distance, wall_distance_i);
          check_field("escaped", 24'(want.escaped), 24'(escaped_i));
          if (want.escaped) escapes_seen_o++;
          else hits_seen_o++;
        end
      end
    end
  end

endmodule

// ===== tb/grid_ray_dda_caster_core_test.sv =====
// Testbench top for the grid ray caster: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module grid_ray_dda_caster_core_test;

  localparam int IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = grdda_pkg::REG_PLAYER_X;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = grdda_pkg::KIND_WRITE;
  logic [10:0] column = '0;
  logic [5:0]  cell_x = '0;
  logic [5:0]  cell_y = '0;
  logic        wall_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] column_out;
  logic [5:0]  hit_x, hit_y;
  logic        hit_side, escaped;
  logic [23:0] wall_distance;
  int          fail_count, pending, hits_seen, escapes_seen;
  int          casts_sent = 0, writes_sent = 0;
  int          hold_req = 0;

  grid_ray_dda_caster_core u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .column_i(column), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .wall_bit_i(wall_bit),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .column_out_o(column_out), .hit_x_o(hit_x), .hit_y_o(hit_y),
    .hit_side_o(hit_side), .wall_distance_o(wall_distance), .escaped_o(escaped)
  );

  grid_ray_dda_caster_core_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .kind_i(kind), .column_i(column), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .wall_bit_i(wall_bit),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .column_out_i(column_out), .hit_x_i(hit_x), .hit_y_i(hit_y),
    .hit_side_i(hit_side), .wall_distance_i(wall_distance), .escaped_i(escaped),
    .fail_count_o(fail_count), .pending_o(pending),
    .hits_seen_o(hits_seen), .escapes_seen_o(escapes_seen)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stalls: a stall mode drawn at random on a tick counter, plus long holds on request.
  always @(posedge clk_i) begin
    static int mode = 0, tick = 0, hold_done = 0, hold_left = 0;
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = 600;
    end
    if (tick % 64 == 0) mode = $urandom_range(0, 3);
    tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= tick[0];
      endcase
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    static int quiet = 0;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One input transfer; valid stays high for a following item.
  task automatic send(input logic k, input logic [10:0] col, input logic [5:0] cx,
                      input logic [5:0] cy, input logic wb);
    in_valid <= 1'b1;
    kind     <= k;
    column   <= col;
    cell_x   <= cx;
    cell_y   <= cy;
    wall_bit <= wb;
    do @(posedge clk_i); while (in_stall);
    if (k == grdda_pkg::KIND_CAST) casts_sent++;
    else writes_sent++;
  endtask

  task automatic cast(input logic [10:0] col);
    send(grdda_pkg::KIND_CAST, col, 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic put_cell(input logic [5:0] cx, input logic [5:0] cy, input logic wb);
    send(grdda_pkg::KIND_WRITE, 11'($urandom), cx, cy, wb);
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has arrived and the block settles.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  // Write all seven registers on consecutive cycles; the block must be idle.
  task automatic configure(input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] vx, input logic [15:0] vy,
                           input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] sw);
    logic [15:0] vals [7];
    vals = '{px, py, vx, vy, cx, cy, sw};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_q214();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 2047)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [5:0] bx, by;
    int phase_items;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default view, corner cells, a rewritten cell, edge columns.
    put_cell(6'd0, 6'd0, 1'b1);
    put_cell(6'd63, 6'd63, 1'b1);
    put_cell(6'd8, 6'd1, 1'b1);
    put_cell(6'd8, 6'd1, 1'b0);
    put_cell(6'd5, 6'd1, 1'b1);
    cast(11'd0);
    cast(11'd320);
    cast(11'd639);
    cast(11'd1023);
    cast(11'd2047);
    drain();
    // Zero ray components and zero screen width.
    configure(16'd1536, 16'd1536, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    cast(11'd0);
    cast(11'd2047);
    drain();
    // Extreme position and directions, widest screen.
    configure(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd4095);
    cast(11'd0);
    cast(11'd2047);
    drain();
    configure(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd1);
    cast(11'd0);
    cast(11'd1);
    cast(11'd2047);
    drain();

    // Random phases: new view, then random wall writes mixed with bursts of casts.
    for (int ph = 0; ph < 12; ph++) begin
      configure(16'($urandom), 16'($urandom), pick_q214(), pick_q214(), pick_q214(),
                pick_q214(), (ph % 4 == 0) ? 16'd2048 : 16'($urandom_range(1, 2048)));
      phase_items = 0;
      while (phase_items < 38) begin
        bx = 6'($urandom);
        by = 6'($urandom);
        if ($urandom_range(0, 9) < 3)
          put_cell(bx, by, 1'($urandom_range(0, 2) != 0));
        else
          cast(11'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 700)));
        phase_items++;
        if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 30));
        if (ph == 3 && phase_items == 10) hold_req <= hold_req + 1;
      end
      if (ph == 6) drain();
      drain();
    end

    drain();
    $display("Ran %0d casts and %0d map writes over 16 view settings.", casts_sent,
             writes_sent);
    $display("Checked %0d wall hits and %0d escapes.", hits_seen, escapes_seen);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
